### design/mmf_pkg.sv
`default_nettype none

package mmf_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 7;
	localparam logic [LEN_W-1:0] CAP_MAX = 7'd64;

	typedef enum logic [1:0] {
		REQ_RESET = 2'd0,
		REQ_SEND  = 2'd1,
		REQ_RECV  = 2'd2,
		REQ_CLOSE = 2'd3
	} req_kind_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [BYTE_W-1:0] send_byte;
		logic              send_last;
		logic [LEN_W-1:0]  capacity;
	} req_t;

	typedef struct packed {
		logic              accepted;
		logic [BYTE_W-1:0] recv_byte;
		logic [LEN_W-1:0]  message_length;
		logic              result_last;
	} rsp_t;

	typedef struct packed {
		req_kind_t         kind;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic [LEN_W-1:0]  cap;
	} cmd_t;

	typedef struct packed {
		logic valid;
		rsp_t data;
	} push_t;

	typedef struct packed {
		logic [1:0] count;
		logic       pop;
	} ob_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RX_LEN,
		BK_RX_STREAM
	} back_state_t;

endpackage

`default_nettype wire

### design/message_mailbox_fifo.sv
// Closable mailbox that queues up to SLOTS messages of 1 to MSG_BYTES bytes. Requests enter on
// req; a send takes one beat per byte and answers once on its last byte, a receive answers with
// one beat per byte of the oldest message (or one refusal beat), and reset and close answer with
// one beat each. Send, close and reset beats are processed at one per cycle, those that answer
// only while the result queue has room. A receive first fetches and checks the stored length,
// then streams one byte per cycle from the message RAM while the result queue has room. A two-
// entry request queue and a two-entry result queue let each side stall without holding up the
// other. No clearing pass is needed after reset.
`default_nettype none

module message_mailbox_fifo #(
	parameter int unsigned SLOTS     = 8,
	parameter int unsigned MSG_BYTES = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire mmf_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output mmf_pkg::rsp_t      rsp
);

	logic                cmd_valid;
	mmf_pkg::cmd_t       cmd;
	logic                cmd_pop;
	mmf_pkg::ob_status_t status;
	mmf_pkg::push_t      push;

	mmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	mmf_back #(.SLOTS(SLOTS), .MSG_BYTES(MSG_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.status    (status),
		.push      (push)
	);

	mmf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

### design/mmf_ram.sv
`default_nettype none

module mmf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### design/mmf_front.sv
`default_nettype none

module mmf_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire mmf_pkg::req_t req,
	output logic               cmd_valid,
	output mmf_pkg::cmd_t      cmd,
	input  wire logic          cmd_pop
);

	mmf_pkg::cmd_t dec;
	mmf_pkg::cmd_t q_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;

	always_comb begin
		dec.kind = mmf_pkg::req_kind_t'(req.req_type);
		dec.data = req.send_byte;
		dec.last = req.send_last;
		dec.cap  = (req.capacity > mmf_pkg::CAP_MAX) ? mmf_pkg::CAP_MAX : req.capacity;
	end

	assign req_ready = (cnt_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= dec;
		end
	end

endmodule

`default_nettype wire

### design/mmf_out.sv
`default_nettype none

module mmf_out (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mmf_pkg::push_t push,
	output mmf_pkg::ob_status_t status,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output mmf_pkg::rsp_t       rsp
);

	mmf_pkg::rsp_t q_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign rsp_valid    = (cnt_q != 2'd0);
	assign rsp          = q_q[rd_q];
	assign pop          = rsp_valid && rsp_ready;
	assign status.count = cnt_q;
	assign status.pop   = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push.valid} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			q_q[wr_q] <= push.data;
		end
	end

endmodule

`default_nettype wire

### design/mmf_back.sv
`default_nettype none

module mmf_back #(
	parameter int unsigned SLOTS     = 8,
	parameter int unsigned MSG_BYTES = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	input  wire mmf_pkg::cmd_t       cmd,
	output logic                     cmd_pop,
	input  wire mmf_pkg::ob_status_t status,
	output mmf_pkg::push_t           push
);

	localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned OCC_W = $clog2(SLOTS + 1);
	localparam int unsigned OW    = $clog2(MSG_BYTES + 1);
	localparam int unsigned DEPTH = SLOTS * MSG_BYTES;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned LW    = mmf_pkg::LEN_W;

	localparam logic [SW-1:0]    LAST_SLOT = SW'(SLOTS - 1);
	localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(SLOTS);
	localparam logic [OW-1:0]    OFF_FULL  = OW'(MSG_BYTES);
	localparam logic [AW-1:0]    STRIDE    = AW'(MSG_BYTES);

	mmf_pkg::back_state_t state_q, state_d;

	logic [SW-1:0]    rslot_q, rslot_d;
	logic [SW-1:0]    wslot_q, wslot_d;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic             closed_q, closed_d;
	logic [OW-1:0]    woff_q, woff_d;
	logic             srej_q, srej_d;
	logic [LW-1:0]    cap_q, cap_d;
	logic [LW-1:0]    len_q, len_d;
	logic [LW-1:0]    idx_q, idx_d;

	logic             s1_valid_q, s1_valid_d;
	mmf_pkg::rsp_t    s1_res_q, s1_res_d;
	logic             s1_ram_q, s1_ram_d;

	logic [2:0]       level;
	logic             can_issue;
	logic             room;
	logic             woff_full;
	logic [OW-1:0]    woff_inc;
	logic             send_ok;
	logic             recv_empty;
	logic             len_reject;
	logic             last_byte;

	logic             st_we;
	logic [AW-1:0]    st_waddr;
	logic [AW-1:0]    st_raddr;
	logic [7:0]       st_rdata;
	logic             ln_we;
	logic [LW-1:0]    ln_rdata;

	assign level      = 3'(status.count) - 3'(status.pop) + 3'(s1_valid_q);
	assign can_issue  = (level < 3'd2);
	assign room       = !closed_q && (occ_q < OCC_FULL);
	assign woff_full  = (woff_q >= OFF_FULL);
	assign woff_inc   = woff_full ? woff_q : woff_q + OW'(1);
	assign send_ok    = room && !srej_q && !woff_full;
	assign recv_empty = (occ_q == '0) || (cmd.cap == '0);
	assign len_reject = (ln_rdata == '0) || (cap_q < ln_rdata);
	assign last_byte  = (idx_q == len_q - LW'(1));

	assign st_waddr = AW'(wslot_q) * STRIDE + AW'(woff_q);
	assign st_raddr = AW'(rslot_q) * STRIDE + AW'(idx_q);

	mmf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (cmd.data),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	mmf_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_lens (
		.clk   (clk),
		.we    (ln_we),
		.waddr (wslot_q),
		.wdata (LW'(woff_inc)),
		.raddr (rslot_q),
		.rdata (ln_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mmf_pkg::BK_IDLE: begin
				if (cmd_valid && cmd.kind == mmf_pkg::REQ_RECV && !recv_empty) begin
					state_d = mmf_pkg::BK_RX_LEN;
				end
			end
			mmf_pkg::BK_RX_LEN: begin
				if (!len_reject) begin
					state_d = mmf_pkg::BK_RX_STREAM;
				end else if (can_issue) begin
					state_d = mmf_pkg::BK_IDLE;
				end
			end
			mmf_pkg::BK_RX_STREAM: begin
				if (can_issue && last_byte) begin
					state_d = mmf_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = mmf_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		rslot_d    = rslot_q;
		wslot_d    = wslot_q;
		occ_d      = occ_q;
		closed_d   = closed_q;
		woff_d     = woff_q;
		srej_d     = srej_q;
		cap_d      = cap_q;
		len_d      = len_q;
		idx_d      = idx_q;
		s1_valid_d = 1'b0;
		s1_res_d   = '0;
		s1_ram_d   = 1'b0;
		cmd_pop    = 1'b0;
		st_we      = 1'b0;
		ln_we      = 1'b0;

		s1_res_d.result_last = 1'b1;

		case (state_q)
			mmf_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						mmf_pkg::REQ_SEND: begin
							if (!cmd.last || can_issue) begin
								cmd_pop = 1'b1;
								st_we   = room && !woff_full;
								srej_d  = srej_q || woff_full;
								woff_d  = woff_inc;
								if (cmd.last) begin
									s1_valid_d = 1'b1;
									woff_d     = '0;
									srej_d     = 1'b0;
									if (send_ok) begin
										ln_we                   = 1'b1;
										wslot_d                 = (wslot_q == LAST_SLOT) ?
											'0 : wslot_q + SW'(1);
										occ_d                   = occ_q + OCC_W'(1);
										s1_res_d.accepted       = 1'b1;
										s1_res_d.message_length = LW'(woff_inc);
									end
								end
							end
						end
						mmf_pkg::REQ_RESET: begin
							if (can_issue) begin
								cmd_pop           = 1'b1;
								woff_d            = '0;
								srej_d            = 1'b0;
								rslot_d           = '0;
								wslot_d           = '0;
								occ_d             = '0;
								closed_d          = 1'b0;
								s1_valid_d        = 1'b1;
								s1_res_d.accepted = 1'b1;
							end
						end
						mmf_pkg::REQ_CLOSE: begin
							if (can_issue) begin
								cmd_pop           = 1'b1;
								woff_d            = '0;
								srej_d            = 1'b0;
								closed_d          = 1'b1;
								s1_valid_d        = 1'b1;
								s1_res_d.accepted = !closed_q;
							end
						end
						mmf_pkg::REQ_RECV: begin
							if (!recv_empty) begin
								cmd_pop = 1'b1;
								woff_d  = '0;
								srej_d  = 1'b0;
								cap_d   = cmd.cap;
							end else if (can_issue) begin
								cmd_pop    = 1'b1;
								woff_d     = '0;
								srej_d     = 1'b0;
								s1_valid_d = 1'b1;
							end
						end
						default: begin
							cmd_pop = 1'b0;
						end
					endcase
				end
			end
			mmf_pkg::BK_RX_LEN: begin
				if (!len_reject) begin
					len_d = ln_rdata;
					idx_d = '0;
				end else if (can_issue) begin
					s1_valid_d = 1'b1;
				end
			end
			mmf_pkg::BK_RX_STREAM: begin
				if (can_issue) begin
					s1_valid_d              = 1'b1;
					s1_ram_d                = 1'b1;
					s1_res_d.accepted       = 1'b1;
					s1_res_d.message_length = len_q;
					s1_res_d.result_last    = last_byte;
					idx_d                   = idx_q + LW'(1);
					if (last_byte) begin
						rslot_d = (rslot_q == LAST_SLOT) ? '0 : rslot_q + SW'(1);
						occ_d   = occ_q - OCC_W'(1);
					end
				end
			end
			default: begin
				s1_valid_d = 1'b0;
			end
		endcase
	end

	always_comb begin
		push.valid = s1_valid_q;
		push.data  = s1_res_q;
		if (s1_ram_q) begin
			push.data.recv_byte = st_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mmf_pkg::BK_IDLE;
			rslot_q    <= '0;
			wslot_q    <= '0;
			occ_q      <= '0;
			closed_q   <= 1'b0;
			woff_q     <= '0;
			srej_q     <= 1'b0;
			s1_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rslot_q    <= rslot_d;
			wslot_q    <= wslot_d;
			occ_q      <= occ_d;
			closed_q   <= closed_d;
			woff_q     <= woff_d;
			srej_q     <= srej_d;
			s1_valid_q <= s1_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cap_q    <= cap_d;
		len_q    <= len_d;
		idx_q    <= idx_d;
		s1_res_q <= s1_res_d;
		s1_ram_q <= s1_ram_d;
	end

`ifndef NO_ASSERTIONS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("ring occupancy exceeds slot count");

	a_woff_bound: assert property (@(posedge clk) disable iff (!arst_n)
		woff_q <= OFF_FULL)
		else $error("send offset exceeds message size");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (3'(status.count) - 3'(status.pop)) < 3'd2)
		else $error("result beat pushed into a full output queue");

	a_stream_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mmf_pkg::BK_RX_STREAM |-> (occ_q != '0) && (idx_q < len_q))
		else $error("receive stream without a stored message");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid && state_q == mmf_pkg::BK_IDLE)
		else $error("command taken outside idle state");
`endif

endmodule

`default_nettype wire
